// ===== design/assert_macros.svh =====
// Assertion macros shared by the set intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define SID_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a same-cycle implication.
`define SID_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication whose consequent must hold in the next cycle.
`define SID_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sid_pkg.sv =====
// Types and constants for the distinct set intersection core.
`default_nettype none
package sid_pkg;

    localparam int FIRST_DEPTH  = 64;
    localparam int RESULT_DEPTH = 64;

    localparam int FIRST_AW  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
    localparam int RESULT_AW = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
    localparam int FIRST_CW  = $clog2(FIRST_DEPTH + 1);
    localparam int RESULT_CW = $clog2(RESULT_DEPTH + 1);
    localparam int IDX_W     = (FIRST_CW > RESULT_CW) ? FIRST_CW : RESULT_CW;

    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 2;

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_PROBE = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] func;
        value_t     value;
    } start_t;

    typedef struct packed {
        logic   valid;
        logic   emit;
        logic   full;
        value_t member;
    } done_t;

endpackage
`default_nettype wire

// ===== design/sid_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module sid_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/sid_seq.sv =====
// Sequencer: scans both stores through one shared comparator and updates them.
`default_nettype none
`include "assert_macros.svh"
module sid_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sid_pkg::start_t start,
    input  wire logic            out_free,
    output logic                 ready,
    output sid_pkg::done_t       done
);

    sid_pkg::state_t state_reg, state_next;
    sid_pkg::func_t  func_reg, func_next;
    sid_pkg::value_t value_reg, value_next;
    logic [sid_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [sid_pkg::FIRST_CW-1:0]  first_count_reg, first_count_next;
    logic [sid_pkg::RESULT_CW-1:0] result_count_reg, result_count_next;
    logic pend_reg, pend_next;
    logic hit_reg, hit_next;
    logic emit_reg, emit_next;
    logic full_reg, full_next;

    logic [sid_pkg::IDX_W-1:0] first_count_ext, result_count_ext;
    logic issue;
    logic cmp_eq;
    sid_pkg::value_t cmp_q;

    logic a_we, a_re, b_we, b_re;
    sid_pkg::value_t a_rdata, b_rdata;

    sid_ram #(
        .DEPTH (sid_pkg::FIRST_DEPTH),
        .WIDTH (sid_pkg::VALUE_W)
    ) u_first_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (first_count_reg[sid_pkg::FIRST_AW-1:0]),
        .wdata (value_reg),
        .re    (a_re),
        .raddr (idx_reg[sid_pkg::FIRST_AW-1:0]),
        .rdata (a_rdata)
    );

    sid_ram #(
        .DEPTH (sid_pkg::RESULT_DEPTH),
        .WIDTH (sid_pkg::VALUE_W)
    ) u_result_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (result_count_reg[sid_pkg::RESULT_AW-1:0]),
        .wdata (value_reg),
        .re    (b_re),
        .raddr (idx_reg[sid_pkg::RESULT_AW-1:0]),
        .rdata (b_rdata)
    );

    assign first_count_ext  = sid_pkg::IDX_W'(first_count_reg);
    assign result_count_ext = sid_pkg::IDX_W'(result_count_reg);

    // Shared comparator: the read data of whichever store is being scanned.
    assign cmp_q  = (state_reg == sid_pkg::ST_SCAN_B) ? b_rdata : a_rdata;
    assign cmp_eq = pend_reg && (cmp_q == value_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= sid_pkg::ST_IDLE;
            first_count_reg  <= '0;
            result_count_reg <= '0;
            pend_reg         <= 1'b0;
        end else begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            result_count_reg <= result_count_next;
            pend_reg         <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        emit_reg  <= emit_next;
        full_reg  <= full_next;
    end

    always_comb begin
        state_next        = state_reg;
        func_next         = func_reg;
        value_next        = value_reg;
        idx_next          = idx_reg;
        first_count_next  = first_count_reg;
        result_count_next = result_count_reg;
        pend_next         = 1'b0;
        hit_next          = hit_reg | cmp_eq;
        emit_next         = emit_reg;
        full_next         = full_reg;
        issue             = 1'b0;
        a_we              = 1'b0;
        a_re              = 1'b0;
        b_we              = 1'b0;
        b_re              = 1'b0;
        ready             = 1'b0;
        done              = '0;
        done.emit         = emit_reg;
        done.full         = full_reg;
        done.member       = value_reg;

        unique case (state_reg)
            sid_pkg::ST_IDLE: begin
                ready      = 1'b1;
                emit_next  = 1'b0;
                full_next  = 1'b0;
                hit_next   = 1'b0;
                idx_next   = '0;
                if (start.valid) begin
                    func_next  = sid_pkg::func_t'(start.func);
                    value_next = start.value;
                    state_next = sid_pkg::ST_FINISH;
                    unique case (sid_pkg::func_t'(start.func))
                        sid_pkg::FUNC_LOAD: begin
                            if (first_count_reg < sid_pkg::FIRST_CW'(sid_pkg::FIRST_DEPTH)) begin
                                // write needs the captured value: done in ST_FINISH once the output register is free
                                state_next = sid_pkg::ST_FINISH;
                            end else begin
                                full_next = 1'b1;
                            end
                        end
                        sid_pkg::FUNC_PROBE: begin
                            state_next = sid_pkg::ST_SCAN_A;
                        end
                        sid_pkg::FUNC_CLEAR: begin
                            first_count_next  = '0;
                            result_count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sid_pkg::ST_SCAN_A: begin
                issue = idx_reg < first_count_ext;
                a_re  = issue;
                pend_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    idx_next = '0;
                    hit_next = 1'b0;
                    state_next = hit_reg ? sid_pkg::ST_SCAN_B : sid_pkg::ST_FINISH;
                end
            end
            sid_pkg::ST_SCAN_B: begin
                issue = idx_reg < result_count_ext;
                b_re  = issue;
                pend_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = sid_pkg::ST_FINISH;
                    if (!hit_reg) begin
                        if (result_count_reg < sid_pkg::RESULT_CW'(sid_pkg::RESULT_DEPTH)) begin
                            b_we              = 1'b1;
                            result_count_next = result_count_reg + 1'b1;
                            emit_next         = 1'b1;
                        end else begin
                            full_next = 1'b1;
                        end
                    end
                end
            end
            sid_pkg::ST_FINISH: begin
                // hold the result until the output register can take it
                if (out_free) begin
                    done.valid = 1'b1;
                    state_next = sid_pkg::ST_IDLE;
                    if (func_reg == sid_pkg::FUNC_LOAD && !full_reg) begin
                        a_we             = 1'b1;
                        first_count_next = first_count_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = sid_pkg::ST_IDLE;
            end
        endcase
    end

    `SID_ASSERT(a_first_count_range, first_count_reg <= sid_pkg::FIRST_CW'(sid_pkg::FIRST_DEPTH), "first-set count beyond depth")
    `SID_ASSERT(a_result_count_range, result_count_reg <= sid_pkg::RESULT_CW'(sid_pkg::RESULT_DEPTH), "result count beyond depth")
    `SID_ASSERT_IMP(a_emit_full_excl, done.valid, !(done.emit && done.full), "emit and store_full together")
    `SID_ASSERT_IMP(a_pend_in_scan, pend_reg, state_reg == sid_pkg::ST_SCAN_A || state_reg == sid_pkg::ST_SCAN_B, "compare pending outside a scan")
    `SID_ASSERT_NXT(a_start_leaves_idle, start.valid && ready, state_reg != sid_pkg::ST_IDLE, "accepted transaction left the sequencer idle")

endmodule
`default_nettype wire

// ===== design/set_intersection_distinct_core.sv =====
// Top level of the distinct set intersection core: stream ports and output register.
// Each transaction carries an operation in s_tuser (0 load into the first set, 1 probe,
// 2 clear both sets) and a signed 32-bit value in s_tdata, and gives exactly one result
// transaction echoing the value with emit and store_full flags. A probe scans the
// first-set RAM and, on a hit, the result RAM one entry per cycle through a single
// comparator: for a non-empty store it issues one read per entry, compares the last
// read and then decides; for an empty one it only decides. A finished result sits in
// an output register, so the next transaction is taken while it waits for m_tready; the
// one after that holds in its last cycle until the register drains. Both stores hold 64
// entries; a load or a new member beyond that is dropped and flagged with store_full.
`default_nettype none
module set_intersection_distinct_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] member
    output logic [1:0]       m_tuser    // [0] emit, [1] store_full
);

    sid_pkg::start_t start;
    sid_pkg::done_t  done;
    logic            seq_ready;
    logic            out_free;

    logic                m_valid_reg;
    sid_pkg::value_t     m_data_reg;
    logic [1:0]          m_user_reg;

    assign s_tready    = seq_ready;
    assign start.valid = s_tvalid && seq_ready;
    assign start.func  = s_tuser;
    assign start.value = s_tdata;

    // Output slot is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_tready;

    sid_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_free (out_free),
        .ready    (seq_ready),
        .done     (done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done.valid) begin
            m_data_reg <= done.member;
            m_user_reg <= {done.full, done.emit};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire
